// ===== hw/rtl/pktm_pkg.sv =====
// Package for the parallel keyword token matcher.
// Holds the input function codes, register indexes and the lane status type.
// No dependencies.
package pktm_pkg;

  typedef enum logic [1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_CHAR = 2'd1,
    FUNC_END  = 2'd2,
    FUNC_NONE = 2'd3
  } pktm_func_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_KEYWORD_COUNT   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DELIMITER_COUNT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DELIMITER_BYTES = 2'd2;

  localparam int unsigned MaxDelims = 4;

  typedef struct packed {
    logic drop;    // keyword byte differs from the character, or keyword ended
    logic at_end;  // keyword byte at the current position is zero
  } pktm_lane_st_t;

endpackage

// ===== hw/rtl/pktm_in_if.sv =====
// Input channel of the keyword token matcher: valid/ready plus one input word.
// Uses pktm_pkg for the function code type.
interface pktm_in_if;
  logic                   valid;
  logic                   ready;
  pktm_pkg::pktm_func_e   func;
  logic [7:0]             char_in;
  logic [3:0]             keyword_slot;
  logic [3:0]             char_position;

  modport source (output valid, func, char_in, keyword_slot, char_position, input ready);
  modport sink   (input valid, func, char_in, keyword_slot, char_position, output ready);
endinterface

// ===== hw/rtl/pktm_out_if.sv =====
// Result channel of the keyword token matcher: valid/ready plus one result word.
// No dependencies.
interface pktm_out_if;
  logic       valid;
  logic       ready;
  logic       match_found;
  logic [3:0] match_index;
  logic [4:0] token_length;
  logic       ended_by_delimiter;
  logic       token_overflow;

  modport source (output valid, match_found, match_index, token_length,
                  ended_by_delimiter, token_overflow, input ready);
  modport sink   (input valid, match_found, match_index, token_length,
                  ended_by_delimiter, token_overflow, output ready);
endinterface

// ===== hw/rtl/pktm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pktm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/pktm_lane.sv =====
// One keyword row: its byte store and the compare against the current character.
// Depends on pktm_pkg and pktm_ram.
module pktm_lane #(
  parameter int unsigned KEYWORD_LEN = 16,
  localparam int unsigned AW = (KEYWORD_LEN > 1) ? $clog2(KEYWORD_LEN) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    we_i,
  input  logic [AW-1:0]           waddr_i,
  input  logic [7:0]              wdata_i,
  input  logic [AW-1:0]           raddr_i,
  input  logic [7:0]              char_i,
  output pktm_pkg::pktm_lane_st_t status_o
);

  logic [7:0] ram_rdata;
  logic       byp_hit_q;
  logic [7:0] byp_data_q;
  logic [7:0] cur_byte;

  pktm_ram #(
    .WIDTH (8),
    .DEPTH (KEYWORD_LEN)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // write-through for a load that lands on the address being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_hit_q <= 1'b0;
    end else begin
      byp_hit_q <= we_i && (waddr_i == raddr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      byp_data_q <= wdata_i;
    end
  end

  assign cur_byte        = byp_hit_q ? byp_data_q : ram_rdata;
  assign status_o.at_end = (cur_byte == 8'd0);
  assign status_o.drop   = (cur_byte == 8'd0) || (cur_byte != char_i);

endmodule

// ===== hw/rtl/parallel_keyword_token_matcher.sv =====
// Parallel keyword token matcher. Takes one word per cycle, back to back, while
// no result word waits at a stalled output: load words fill the keyword rows,
// stream characters are compared against every keyword row in the same cycle,
// and a delimiter or end-of-string word closes the token and produces one result
// word (highest equal keyword, length, overflow). From input acceptance to
// result valid, a word goes from the input register through one compare stage
// across all keyword lanes into the result register. The rate of one word per
// cycle is set by that single compare stage; each lane reads its row RAM one
// position ahead of the token. A result word still waiting at the output holds
// every input word in the input register until it is taken.
// No clearing pass after reset; keyword bytes must be loaded before use.
module parallel_keyword_token_matcher #(
  parameter int unsigned KEYWORDS    = 16,
  parameter int unsigned KEYWORD_LEN = 16,
  parameter int unsigned DELIMS      = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pktm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pktm_pkg::CfgDataW-1:0] cfg_wdata_i,
  pktm_in_if.sink                       in_i,
  pktm_out_if.source                    out_o
);

  localparam int unsigned AW   = (KEYWORD_LEN > 1) ? $clog2(KEYWORD_LEN) : 1;
  localparam int unsigned PW   = $clog2(KEYWORD_LEN + 1);
  localparam int unsigned IW   = (KEYWORDS > 1) ? $clog2(KEYWORDS) : 1;
  localparam int unsigned NDEL = (DELIMS < pktm_pkg::MaxDelims) ? DELIMS : pktm_pkg::MaxDelims;

  // configuration
  logic [4:0]  kcnt_q;
  logic [2:0]  dcnt_q;
  logic [31:0] dbytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kcnt_q   <= '0;
      dcnt_q   <= '0;
      dbytes_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pktm_pkg::REG_KEYWORD_COUNT:   kcnt_q   <= cfg_wdata_i[4:0];
        pktm_pkg::REG_DELIMITER_COUNT: dcnt_q   <= cfg_wdata_i[2:0];
        pktm_pkg::REG_DELIMITER_BYTES: dbytes_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                 in_valid_q;
  pktm_pkg::pktm_func_e func_q;
  logic [7:0]           char_q;
  logic [3:0]           slot_q;
  logic [3:0]           cpos_q;
  logic                 proc_fire;
  logic                 out_valid_q;

  assign proc_fire  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q <= in_i.func;
      char_q <= in_i.char_in;
      slot_q <= in_i.keyword_slot;
      cpos_q <= in_i.char_position;
    end
  end

  // token state
  logic [KEYWORDS-1:0] alive_q, alive_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic                ovf_q, ovf_d;

  // keyword lanes
  pktm_pkg::pktm_lane_st_t lane_st [KEYWORDS];
  logic [KEYWORDS-1:0]     drop_vec;
  logic                    load_ok;

  assign load_ok = (32'(slot_q) < KEYWORDS) && (32'(cpos_q) < KEYWORD_LEN);

  for (genvar g = 0; g < KEYWORDS; g++) begin : g_lane
    pktm_lane #(
      .KEYWORD_LEN (KEYWORD_LEN)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .we_i     (proc_fire && (func_q == pktm_pkg::FUNC_LOAD) && load_ok &&
                 (32'(slot_q) == g)),
      .waddr_i  (AW'(cpos_q)),
      .wdata_i  (char_q),
      .raddr_i  (AW'(pos_d)),
      .char_i   (char_q),
      .status_o (lane_st[g])
    );
    assign drop_vec[g] = lane_st[g].drop;
  end

  // delimiter test
  logic is_delim;
  always_comb begin
    is_delim = 1'b0;
    for (int k = 0; k < pktm_pkg::MaxDelims; k++) begin
      if ((k < NDEL) && (3'(k) < dcnt_q) && (dbytes_q[8*k +: 8] == char_q)) begin
        is_delim = 1'b1;
      end
    end
  end

  // close-token search
  logic                len_full;
  logic [KEYWORDS-1:0] hit;
  logic [IW-1:0]       hit_idx;
  logic                found;

  assign len_full = (32'(pos_q) >= KEYWORD_LEN);

  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < KEYWORDS; k++) begin
      hit[k] = (32'(kcnt_q) > k) && alive_q[k] && (len_full || lane_st[k].at_end);
      if (hit[k]) begin
        hit_idx = IW'(k);
      end
    end
  end

  assign found = !ovf_q && (pos_q != '0) && (|hit);

  logic do_close, do_adv, close_delim;
  assign close_delim = (func_q == pktm_pkg::FUNC_CHAR) && is_delim;
  assign do_close    = proc_fire && (close_delim || (func_q == pktm_pkg::FUNC_END));
  assign do_adv      = proc_fire && (func_q == pktm_pkg::FUNC_CHAR) && !is_delim;

  always_comb begin
    alive_d = alive_q;
    pos_d   = pos_q;
    ovf_d   = ovf_q;
    priority if (do_close) begin
      alive_d = '1;
      pos_d   = '0;
      ovf_d   = 1'b0;
    end else if (do_adv) begin
      if (len_full) begin
        ovf_d   = 1'b1;
        alive_d = '0;
      end else begin
        alive_d = alive_q & ~drop_vec;
        pos_d   = pos_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alive_q <= '1;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      alive_q <= alive_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
    end
  end

  // result register
  logic       out_found_q;
  logic [3:0] out_idx_q;
  logic [4:0] out_len_q;
  logic       out_delim_q;
  logic       out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_close) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_close) begin
      out_found_q <= found;
      out_idx_q   <= found ? 4'(hit_idx) : 4'd0;
      out_len_q   <= 5'(pos_q);
      out_delim_q <= close_delim;
      out_ovf_q   <= ovf_q;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.match_found        = out_found_q;
  assign out_o.match_index        = out_idx_q;
  assign out_o.token_length       = out_len_q;
  assign out_o.ended_by_delimiter = out_delim_q;
  assign out_o.token_overflow     = out_ovf_q;

  // checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pos_q) <= KEYWORD_LEN)
    else $error("token position beyond keyword length");

  a_ovf_kills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (alive_q == '0))
    else $error("keyword still alive after overflow");

  a_close_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_close |=> (pos_q == '0) && !ovf_q && out_valid_q)
    else $error("token state not cleared on close");

  a_ovf_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ovf_q) |-> !out_found_q)
    else $error("match reported for an overflowed token");

endmodule
